[rtl/core/fsd_pkg.sv]
package fsd_pkg;

    // Item geometry
    localparam int NUM_SCORES = 5;
    localparam int SCORE_W    = 16;
    localparam int TOTAL_W    = 19;
    localparam int DEV_W      = 17;
    localparam int SQ_W       = 32;
    localparam int SUM_W      = 35;
    localparam int SD_W       = 16;
    localparam int IDX_W      = 3;

    localparam logic [IDX_W-1:0] FIRST_IDX = 3'd0;
    localparam logic [IDX_W-1:0] LAST_IDX  = 3'd4;

    // Mean: (total + 2) / 5 by reciprocal, exact for totals below 2^21 / 3
    localparam int                  ROUND_BIAS = 2;
    localparam int                  MEAN_SHIFT = 21;
    localparam int                  MEAN_PROD_W = TOTAL_W + MEAN_SHIFT;
    localparam logic [MEAN_SHIFT-1:0] MEAN_RECIP = 21'd419431;

    // Sum of squares / 5: long division, 7-bit digit per step
    localparam int           DIG_W     = 7;
    localparam int           REM5_W    = 3;
    localparam int           DIV_SHIFT = 10;
    localparam logic [7:0]   DIV_RECIP = 8'd205;
    localparam int           QHI_W     = 3 * DIG_W;

    // Square root pipeline
    localparam int RAD_W       = 32;
    localparam int ROOT_W      = SD_W;
    localparam int REM_W       = ROOT_W + 2;
    localparam int SQRT_STAGES = 4;
    localparam int SQRT_STEPS  = ROOT_W / SQRT_STAGES;

    // Everything that rides alongside the division and the root
    typedef struct packed {
        logic [NUM_SCORES-1:0][DEV_W-1:0] dev;
        logic [NUM_SCORES-1:0][SQ_W-1:0]  sq;
        logic [SCORE_W-1:0]               mean;
        logic [SUM_W-1:0]                 sum;
    } side_t;

    // One digit of division by five: returns {quotient digit, remainder}
    function automatic logic [DIG_W+REM5_W-1:0] div5_digit(
        input logic [REM5_W-1:0] rem_in,
        input logic [DIG_W-1:0]  digit
    );
        logic [DIG_W+REM5_W-1:0] num;
        logic [17:0]             prod;
        logic [DIG_W-1:0]        quo;
        logic [DIG_W+REM5_W-1:0] back;
        num  = {rem_in, digit};
        prod = 18'(num) * 18'(DIV_RECIP);
        quo  = prod[DIV_SHIFT +: DIG_W];
        back = (DIG_W+REM5_W)'(quo) * (DIG_W+REM5_W)'(NUM_SCORES);
        return {quo, REM5_W'(num - back)};
    endfunction

endpackage

[rtl/core/fsd_sqrt.sv]
// Floor square root, digit by digit, four result bits per register stage.
module fsd_sqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [fsd_pkg::RAD_W-1:0]     radicand,
    output logic                          out_valid,
    output logic [fsd_pkg::ROOT_W-1:0]    root
);

    logic [fsd_pkg::SQRT_STAGES-1:0] vld_reg;
    logic [fsd_pkg::SQRT_STAGES-1:0] vld_next;
    logic [fsd_pkg::REM_W-1:0]       rem_reg  [fsd_pkg::SQRT_STAGES];
    logic [fsd_pkg::ROOT_W-1:0]      root_reg [fsd_pkg::SQRT_STAGES];
    logic [fsd_pkg::RAD_W-1:0]       rad_reg  [fsd_pkg::SQRT_STAGES];

    // Advance the valid bits with the data
    assign vld_next = {vld_reg[fsd_pkg::SQRT_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    for (genvar s = 0; s < fsd_pkg::SQRT_STAGES; s++)
    begin : g_stage
        logic [fsd_pkg::REM_W-1:0]  rem_in;
        logic [fsd_pkg::ROOT_W-1:0] root_in;
        logic [fsd_pkg::RAD_W-1:0]  rad_in;
        logic [fsd_pkg::REM_W-1:0]  rem_next;
        logic [fsd_pkg::ROOT_W-1:0] root_next;
        logic [fsd_pkg::RAD_W-1:0]  rad_next;
        logic [fsd_pkg::REM_W+1:0]  work;
        logic [fsd_pkg::ROOT_W+1:0] trial;

        // Take the radicand at the first stage, the previous stage elsewhere
        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rad_in  = rad_reg[s-1];
        end

        // Bring down two radicand bits, try root*4+1, keep one root bit
        always_comb
        begin
            rem_next  = rem_in;
            root_next = root_in;
            rad_next  = rad_in;
            work      = '0;
            trial     = '0;
            for (int k = 0; k < fsd_pkg::SQRT_STEPS; k++)
            begin
                work     = {rem_next, rad_next[fsd_pkg::RAD_W-1 -: 2]};
                rad_next = rad_next << 2;
                trial    = {root_next, 2'b01};
                if (work >= {2'b00, trial})
                begin
                    rem_next  = fsd_pkg::REM_W'(work - {2'b00, trial});
                    root_next = {root_next[fsd_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = work[fsd_pkg::REM_W-1:0];
                    root_next = {root_next[fsd_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= rem_next;
            root_reg[s] <= root_next;
            rad_reg[s]  <= rad_next;
        end
    end

    assign out_valid = vld_reg[fsd_pkg::SQRT_STAGES-1];
    assign root      = root_reg[fsd_pkg::SQRT_STAGES-1];

endmodule

[rtl/core/five_sample_mean_and_std_dev.sv]
// Five-sample mean and population standard deviation, fixed point.
//
// Command channel: drive score_a..score_e and raise start; the word is
// taken at a rising edge where start is high and busy is low. busy stays
// high after each accepted word while it passes through the busy history,
// which spaces words to match the five result words each one makes.
// Result channel: each result word sits on the result ports for one cycle
// with result_strobe high; score_index counts 0 to 4 and last_item marks
// the fifth. The receiver cannot hold results off and needs no way to.
// The path is seven arithmetic stages (sum, mean by reciprocal,
// deviations, squares, sum of squares, two halves of the division by
// five) followed by the four-stage square root and the output hold
// register. Words overlap in the path: a new word is taken while earlier
// ones are still in flight.
// Reset clears every valid bit, the busy history and the output strobe;
// words in flight are dropped.
module five_sample_mean_and_std_dev
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [fsd_pkg::SCORE_W-1:0]        score_a,
    input  logic [fsd_pkg::SCORE_W-1:0]        score_b,
    input  logic [fsd_pkg::SCORE_W-1:0]        score_c,
    input  logic [fsd_pkg::SCORE_W-1:0]        score_d,
    input  logic [fsd_pkg::SCORE_W-1:0]        score_e,
    output logic                               result_strobe,
    output logic [fsd_pkg::IDX_W-1:0]          score_index,
    output logic signed [fsd_pkg::DEV_W-1:0]   deviation,
    output logic [fsd_pkg::SQ_W-1:0]           squared_deviation,
    output logic [fsd_pkg::SCORE_W-1:0]        mean_value,
    output logic [fsd_pkg::SUM_W-1:0]          sum_of_squares,
    output logic [fsd_pkg::SD_W-1:0]           std_dev,
    output logic                               last_item
);

    localparam int PIPE_STAGES = 7;
    localparam int HIST_W      = fsd_pkg::NUM_SCORES - 1;

    logic                                accept;
    logic [HIST_W-1:0]                   acc_hist_reg;
    logic [HIST_W-1:0]                   acc_hist_next;
    logic [PIPE_STAGES-1:0]              vld_reg;
    logic [PIPE_STAGES-1:0]              vld_next;
    logic [fsd_pkg::SCORE_W-1:0]         score_in [fsd_pkg::NUM_SCORES];

    logic [fsd_pkg::SCORE_W-1:0]         s1_score_reg [fsd_pkg::NUM_SCORES];
    logic [fsd_pkg::TOTAL_W-1:0]         s1_total_reg;
    logic [fsd_pkg::TOTAL_W-1:0]         s1_total_next;

    logic [fsd_pkg::SCORE_W-1:0]         s2_score_reg [fsd_pkg::NUM_SCORES];
    logic [fsd_pkg::SCORE_W-1:0]         s2_mean_reg;
    logic [fsd_pkg::SCORE_W-1:0]         s2_mean_next;
    logic [fsd_pkg::MEAN_PROD_W-1:0]     mean_prod;

    logic [fsd_pkg::DEV_W-1:0]           s3_dev_reg [fsd_pkg::NUM_SCORES];
    logic [fsd_pkg::DEV_W-1:0]           s3_dev_next [fsd_pkg::NUM_SCORES];
    logic [fsd_pkg::SCORE_W-1:0]         s3_mean_reg;

    logic [fsd_pkg::DEV_W-1:0]           s4_dev_reg [fsd_pkg::NUM_SCORES];
    logic [fsd_pkg::SQ_W-1:0]            s4_sq_reg [fsd_pkg::NUM_SCORES];
    logic [fsd_pkg::SQ_W-1:0]            s4_sq_next [fsd_pkg::NUM_SCORES];
    logic [fsd_pkg::DEV_W-1:0]           dev_mag [fsd_pkg::NUM_SCORES];
    logic [fsd_pkg::SCORE_W-1:0]         s4_mean_reg;

    fsd_pkg::side_t                      s5_side_reg;
    fsd_pkg::side_t                      s5_side_next;

    fsd_pkg::side_t                      s6_side_reg;
    logic [fsd_pkg::QHI_W-1:0]           s6_qhi_reg;
    logic [fsd_pkg::QHI_W-1:0]           s6_qhi_next;
    logic [fsd_pkg::REM5_W-1:0]          s6_rem_reg;
    logic [fsd_pkg::REM5_W-1:0]          s6_rem_next;

    fsd_pkg::side_t                      s7_side_reg;
    logic [fsd_pkg::RAD_W-1:0]           s7_quot_reg;
    logic [fsd_pkg::RAD_W-1:0]           s7_quot_next;

    logic                                sqrt_vld;
    logic [fsd_pkg::ROOT_W-1:0]          sqrt_root;
    fsd_pkg::side_t                      side_dly_reg [fsd_pkg::SQRT_STAGES];
    logic [fsd_pkg::SQRT_STAGES-1:0]     side_vld_reg;
    logic [fsd_pkg::SQRT_STAGES-1:0]     side_vld_next;

    fsd_pkg::side_t                      hold_reg;
    logic [fsd_pkg::SD_W-1:0]            sd_reg;
    logic [fsd_pkg::IDX_W-1:0]           cnt_reg;
    logic [fsd_pkg::IDX_W-1:0]           cnt_next;
    logic                                active_reg;
    logic                                active_next;

    // Command handshake: block new words while the accept history holds any accepted word
    assign busy          = |acc_hist_reg;
    assign accept        = start && !busy;
    assign acc_hist_next = {acc_hist_reg[HIST_W-2:0], accept};
    assign vld_next      = {vld_reg[PIPE_STAGES-2:0], accept};
    assign side_vld_next = {side_vld_reg[fsd_pkg::SQRT_STAGES-2:0],
                            vld_reg[PIPE_STAGES-1]};

    assign score_in[0] = score_a;
    assign score_in[1] = score_b;
    assign score_in[2] = score_c;
    assign score_in[3] = score_d;
    assign score_in[4] = score_e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_hist_reg <= '0;
            vld_reg      <= '0;
            side_vld_reg <= '0;
            cnt_reg      <= fsd_pkg::FIRST_IDX;
            active_reg   <= 1'b0;
        end
        else
        begin
            acc_hist_reg <= acc_hist_next;
            vld_reg      <= vld_next;
            side_vld_reg <= side_vld_next;
            cnt_reg      <= cnt_next;
            active_reg   <= active_next;
        end
    end

    // Stage 1: total of the five scores
    always_comb
    begin
        s1_total_next = '0;
        for (int i = 0; i < fsd_pkg::NUM_SCORES; i++)
        begin
            s1_total_next = s1_total_next + fsd_pkg::TOTAL_W'(score_in[i]);
        end
    end

    // Stage 2: mean = (total + 2) / 5 by multiplying with the reciprocal
    assign mean_prod = fsd_pkg::MEAN_PROD_W'(s1_total_reg
                           + fsd_pkg::TOTAL_W'(fsd_pkg::ROUND_BIAS))
                       * fsd_pkg::MEAN_PROD_W'(fsd_pkg::MEAN_RECIP);
    assign s2_mean_next = mean_prod[fsd_pkg::MEAN_SHIFT +: fsd_pkg::SCORE_W];

    // Stage 3: signed deviations; stage 4: their squares
    always_comb
    begin
        for (int i = 0; i < fsd_pkg::NUM_SCORES; i++)
        begin
            s3_dev_next[i] = fsd_pkg::DEV_W'(s2_score_reg[i])
                             - fsd_pkg::DEV_W'(s2_mean_reg);
            dev_mag[i]     = s3_dev_reg[i][fsd_pkg::DEV_W-1] ? (~s3_dev_reg[i] + 1'b1)
                                                             : s3_dev_reg[i];
            s4_sq_next[i]  = fsd_pkg::SQ_W'(dev_mag[i][fsd_pkg::SCORE_W-1:0])
                             * fsd_pkg::SQ_W'(dev_mag[i][fsd_pkg::SCORE_W-1:0]);
        end
    end

    // Stage 5: sum of squares, and pack the side data
    always_comb
    begin
        s5_side_next.mean = s4_mean_reg;
        s5_side_next.sum  = '0;
        for (int i = 0; i < fsd_pkg::NUM_SCORES; i++)
        begin
            s5_side_next.dev[i] = s4_dev_reg[i];
            s5_side_next.sq[i]  = s4_sq_reg[i];
            s5_side_next.sum    = s5_side_next.sum + fsd_pkg::SUM_W'(s4_sq_reg[i]);
        end
    end

    // Stage 6: divide the top three digits of the sum by five
    always_comb
    begin
        logic [fsd_pkg::DIG_W+fsd_pkg::REM5_W-1:0] dq;
        dq          = '0;
        s6_rem_next = '0;
        s6_qhi_next = '0;
        for (int k = 4; k >= 2; k--)
        begin
            dq = fsd_pkg::div5_digit(s6_rem_next,
                                     s5_side_reg.sum[k*fsd_pkg::DIG_W +: fsd_pkg::DIG_W]);
            s6_qhi_next[(k-2)*fsd_pkg::DIG_W +: fsd_pkg::DIG_W] = dq[fsd_pkg::REM5_W +:
                                                                     fsd_pkg::DIG_W];
            s6_rem_next = dq[fsd_pkg::REM5_W-1:0];
        end
    end

    // Stage 7: finish the division with the two low digits
    always_comb
    begin
        logic [fsd_pkg::DIG_W+fsd_pkg::REM5_W-1:0] dq1;
        logic [fsd_pkg::DIG_W+fsd_pkg::REM5_W-1:0] dq0;
        dq1 = fsd_pkg::div5_digit(s6_rem_reg,
                                  s6_side_reg.sum[fsd_pkg::DIG_W +: fsd_pkg::DIG_W]);
        dq0 = fsd_pkg::div5_digit(dq1[fsd_pkg::REM5_W-1:0],
                                  s6_side_reg.sum[fsd_pkg::DIG_W-1:0]);
        s7_quot_next = fsd_pkg::RAD_W'({s6_qhi_reg,
                                        dq1[fsd_pkg::REM5_W +: fsd_pkg::DIG_W],
                                        dq0[fsd_pkg::REM5_W +: fsd_pkg::DIG_W]});
    end

    // Pipeline data registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < fsd_pkg::NUM_SCORES; i++)
        begin
            s1_score_reg[i] <= score_in[i];
            s2_score_reg[i] <= s1_score_reg[i];
            s3_dev_reg[i]   <= s3_dev_next[i];
            s4_dev_reg[i]   <= s3_dev_reg[i];
            s4_sq_reg[i]    <= s4_sq_next[i];
        end
        s1_total_reg <= s1_total_next;
        s2_mean_reg  <= s2_mean_next;
        s3_mean_reg  <= s2_mean_reg;
        s4_mean_reg  <= s3_mean_reg;
        s5_side_reg  <= s5_side_next;
        s6_side_reg  <= s5_side_reg;
        s6_qhi_reg   <= s6_qhi_next;
        s6_rem_reg   <= s6_rem_next;
        s7_side_reg  <= s6_side_reg;
        s7_quot_reg  <= s7_quot_next;
    end

    fsd_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[PIPE_STAGES-1]),
        .radicand  (s7_quot_reg),
        .out_valid (sqrt_vld),
        .root      (sqrt_root)
    );

    // Delay the side data to line up with the root
    always_ff @(posedge clk)
    begin
        side_dly_reg[0] <= s7_side_reg;
        for (int j = 1; j < fsd_pkg::SQRT_STAGES; j++)
        begin
            side_dly_reg[j] <= side_dly_reg[j-1];
        end
    end

    // Output sequencer: load a finished word, then step through five results
    always_comb
    begin
        cnt_next    = cnt_reg;
        active_next = active_reg;
        if (sqrt_vld)
        begin
            cnt_next    = fsd_pkg::FIRST_IDX;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            if (cnt_reg == fsd_pkg::LAST_IDX)
            begin
                active_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sqrt_vld)
        begin
            hold_reg <= side_dly_reg[fsd_pkg::SQRT_STAGES-1];
            sd_reg   <= sqrt_root;
        end
    end

    // Drive the result ports from the hold register
    assign result_strobe     = active_reg;
    assign score_index       = cnt_reg;
    assign deviation         = signed'(hold_reg.dev[cnt_reg]);
    assign squared_deviation = hold_reg.sq[cnt_reg];
    assign mean_value        = hold_reg.mean;
    assign sum_of_squares    = hold_reg.sum;
    assign std_dev           = sd_reg;
    assign last_item         = (cnt_reg == fsd_pkg::LAST_IDX);

    // Root and side data leave their delay lines together
    a_side_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_vld == side_vld_reg[fsd_pkg::SQRT_STAGES-1])
        else $error("root and side data out of step");

    // A new word reaches the output only once the previous one is fully sent
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_vld |-> (!active_reg || cnt_reg == fsd_pkg::LAST_IDX))
        else $error("result word overwritten before all results were sent");

    // Index never runs past the fifth score while results are shown
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (cnt_reg <= fsd_pkg::LAST_IDX))
        else $error("score index out of range");

    // After the last result either the strobe drops or a new run starts at 0
    a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_item) |=> (!result_strobe
                                          || score_index == fsd_pkg::FIRST_IDX))
        else $error("result run did not restart at the first score");

    // Results follow one another without gaps inside a run
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last_item) |=> (result_strobe
                                           && score_index == $past(score_index) + 1'b1))
        else $error("gap or skip inside a result run");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;

    import fsd_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_GAP = 18;
    localparam int TAIL_CYCLES = 24;
    localparam int IDLE_LIMIT = 600;
    localparam int DIRECTED_BURST = 20;
    localparam int RANDOM_WORDS = 140;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    // One result word as the block should present it
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [DEV_W-1:0]   dev;
        logic [SQ_W-1:0]    sq;
        logic [SCORE_W-1:0] mean;
        logic [SUM_W-1:0]   sum;
        logic [SD_W-1:0]    sd;
        logic               last;
    } score_result_t;

    typedef logic [NUM_SCORES-1:0][SCORE_W-1:0] score_set_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [SCORE_W-1:0]        score_a;
    logic [SCORE_W-1:0]        score_b;
    logic [SCORE_W-1:0]        score_c;
    logic [SCORE_W-1:0]        score_d;
    logic [SCORE_W-1:0]        score_e;
    logic                      result_strobe;
    logic [IDX_W-1:0]          score_index;
    logic signed [DEV_W-1:0]   deviation;
    logic [SQ_W-1:0]           squared_deviation;
    logic [SCORE_W-1:0]        mean_value;
    logic [SUM_W-1:0]          sum_of_squares;
    logic [SD_W-1:0]           std_dev;
    logic                      last_item;

    score_result_t pending_results[$];
    int            error_count = 0;
    int            idle_cycles = 0;
    bit            no_gaps = 1'b0;

    five_sample_mean_and_std_dev dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .score_a           (score_a),
        .score_b           (score_b),
        .score_c           (score_c),
        .score_d           (score_d),
        .score_e           (score_e),
        .result_strobe     (result_strobe),
        .score_index       (score_index),
        .deviation         (deviation),
        .squared_deviation (squared_deviation),
        .mean_value        (mean_value),
        .sum_of_squares    (sum_of_squares),
        .std_dev           (std_dev),
        .last_item         (last_item)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    // Exact floor square root, one result bit per pass from the top
    function automatic logic [SD_W-1:0] floor_root(input logic [SUM_W-1:0] radicand);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = SD_W - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= 64'(radicand))
                root = trial;
        end
        return root[SD_W-1:0];
    endfunction

    // Work out the five result words of one score set and queue them
    task automatic queue_score_results(input score_set_t s);
        logic [TOTAL_W-1:0]     total;
        logic [SCORE_W-1:0]     mean;
        logic signed [DEV_W:0]  diff [NUM_SCORES];
        logic [SQ_W-1:0]        sq [NUM_SCORES];
        logic [SUM_W-1:0]       sum;
        logic [SD_W-1:0]        sd;
        score_result_t          r;
        total = '0;
        for (int i = 0; i < NUM_SCORES; i++)
            total += TOTAL_W'(s[i]);
        mean = SCORE_W'((total + TOTAL_W'(2)) / TOTAL_W'(5));
        sum = '0;
        for (int i = 0; i < NUM_SCORES; i++)
        begin
            diff[i] = $signed({2'b00, s[i]}) - $signed({2'b00, mean});
            sq[i] = SQ_W'(64'(diff[i]) * 64'(diff[i]));
            sum += SUM_W'(sq[i]);
        end
        sd = floor_root(sum / SUM_W'(5));
        for (int i = 0; i < NUM_SCORES; i++)
        begin
            r.idx  = IDX_W'(i);
            r.dev  = diff[i][DEV_W-1:0];
            r.sq   = sq[i];
            r.mean = mean;
            r.sum  = sum;
            r.sd   = sd;
            r.last = (i == NUM_SCORES - 1);
            pending_results.push_back(r);
        end
    endtask

    // Present one score set, hold it until taken, then predict its results
    task automatic send_scores(input score_set_t s);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start   = 1'b0;
            score_a = SCORE_W'($urandom);
            score_b = SCORE_W'($urandom);
            score_c = SCORE_W'($urandom);
            score_d = SCORE_W'($urandom);
            score_e = SCORE_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        score_a = s[0];
        score_b = s[1];
        score_c = s[2];
        score_d = s[3];
        score_e = s[4];
        start   = 1'b1;
        do
            @(posedge clk);
        while (busy);
        queue_score_results(s);
        @(negedge clk);
    endtask

    function automatic score_set_t random_scores();
        score_set_t s;
        int         kind;
        int         base;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < NUM_SCORES; i++)
        begin
            case (kind)
                5, 6:
                begin
                    // tight cluster: small deviations, small root
                    if (i == 0)
                        base = $urandom_range(0, 65535 - 64);
                    s[i] = SCORE_W'(base + $urandom_range(0, 63));
                end
                7:       s[i] = SCORE_W'($urandom_range(0, 31));
                8:       s[i] = $urandom_range(0, 1) ? SCORE_MAX : '0;
                default: s[i] = SCORE_W'($urandom);
            endcase
        end
        if (kind == 9)
            s[$urandom_range(0, NUM_SCORES - 1)] = $urandom_range(0, 1) ? SCORE_MAX : '0;
        return s;
    endfunction

    // Full-scale and bit-pattern corners
    task automatic test_extremes();
        send_scores({NUM_SCORES{16'h0000}});
        send_scores({NUM_SCORES{SCORE_MAX}});
        send_scores({16'h0000, 16'h0000, 16'h0000, 16'h0000, SCORE_MAX});
        send_scores({SCORE_MAX, SCORE_MAX, SCORE_MAX, SCORE_MAX, 16'h0000});
        send_scores({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        send_scores({16'h0001, 16'h8000, 16'h0010, 16'h0100, 16'h1000});
        send_scores({SCORE_MAX, 16'h0000, SCORE_MAX, 16'h0000, SCORE_MAX});
    endtask

    // Mean remainders of zero to four fifths: up only on three and four
    task automatic test_mean_rounding();
        for (int rem = 0; rem < NUM_SCORES; rem++)
            send_scores({16'd100, 16'd100, 16'd100, 16'd100, SCORE_W'(100 + rem)});
        send_scores({16'd0, 16'd0, 16'd0, 16'd1, 16'd2});
        send_scores({16'd0, 16'd0, 16'd0, 16'd0, 16'd4});
    endtask

    // Root on and just off exact squares
    task automatic test_root_corners();
        send_scores({16'd0, 16'd0, 16'd0, 16'd0, 16'd5});
        send_scores({16'd0, 16'd0, 16'd0, 16'd0, 16'd6});
        send_scores({16'd16, 16'd32, 16'd48, 16'd64, 16'd80});
        send_scores({16'd7, 16'd7, 16'd7, 16'd7, 16'd7});
        send_scores({16'd0, 16'd0, 16'd0, 16'd0, 16'd3});
    endtask

    // Words offered as fast as busy allows
    task automatic test_back_to_back();
        no_gaps = 1'b1;
        for (int n = 0; n < DIRECTED_BURST; n++)
            send_scores(random_scores());
        no_gaps = 1'b0;
    endtask

    // Mixed random sets with random gaps and occasional bursts
    task automatic test_random_sets();
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if ($urandom_range(0, 15) == 0)
                no_gaps = ~no_gaps;
            send_scores(random_scores());
        end
        no_gaps = 1'b0;
    endtask

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Check each result word against the oldest prediction
    always @(posedge clk)
    begin
        score_result_t want;
        if (rst_n && result_strobe)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected: index %0d", score_index);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("score_index", want.idx, score_index);
                compare_field("deviation", $signed(want.dev), deviation);
                compare_field("squared_deviation", want.sq, squared_deviation);
                compare_field("mean_value", want.mean, mean_value);
                compare_field("sum_of_squares", want.sum, sum_of_squares);
                compare_field("std_dev", want.sd, std_dev);
                compare_field("last_item", want.last, last_item);
            end
        end
    end

    // Drop the run if no word moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        score_a = '0;
        score_b = '0;
        score_c = '0;
        score_d = '0;
        score_e = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_extremes();
        test_mean_rounding();
        test_root_corners();
        test_back_to_back();
        test_random_sets();
        start = 1'b0;

        // Drain, then allow stray words to show up
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/fsd_pkg.sv
rtl/core/fsd_sqrt.sv
rtl/core/five_sample_mean_and_std_dev.sv
tb/sv/tb.sv
